// ===== sv/dual_window_sensitivity_classifier_core_defines.svh =====
// Assertion macros used by the top-level RTL file of the classifier core.
`ifndef DUAL_WINDOW_SENSITIVITY_CLASSIFIER_CORE_DEFINES_SVH
`define DUAL_WINDOW_SENSITIVITY_CLASSIFIER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define DWSC_ASSERT_IMPL(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("implication check failed");
`define DWSC_ASSERT_NEVER(lbl, clk_s, rstn_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
    else $error("forbidden condition seen");
`else
`define DWSC_ASSERT_IMPL(lbl, clk_s, rstn_s, prop)
`define DWSC_ASSERT_NEVER(lbl, clk_s, rstn_s, cond)
`endif

`endif

// ===== sv/dwsc_pkg.sv =====
`default_nettype none

package dwsc_pkg;

  localparam int unsigned DATA_W          = 32;
  localparam int unsigned SHORT_LEN_W     = 7;
  localparam int unsigned LONG_LEN_W      = 9;
  localparam int unsigned PCT_W           = 7;
  localparam int unsigned CLASS_W         = 2;
  localparam int unsigned SHORT_CNT_OUT_W = 7;
  localparam int unsigned LONG_CNT_OUT_W  = 9;
  localparam int unsigned CFG_IDX_W       = 3;

  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_LEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PCT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PCT  = 3'd4;

  typedef enum logic [CLASS_W-1:0] {
    CLS_UNKNOWN  = 2'd0,
    CLS_NOT_SENS = 2'd1,
    CLS_SENS     = 2'd2
  } class_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_bandwidth;
    logic [DATA_W-1:0] page_in_rate;
  } in_word_t;

  typedef struct packed {
    logic [CLASS_W-1:0]         class_code;
    logic                       sample_hot;
    logic [SHORT_CNT_OUT_W-1:0] short_count;
    logic [LONG_CNT_OUT_W-1:0]  long_count;
  } out_word_t;

  typedef struct packed {
    logic [DATA_W-1:0]      threshold;
    logic [SHORT_LEN_W-1:0] short_len;
    logic [LONG_LEN_W-1:0]  long_len;
    logic [PCT_W-1:0]       short_pct;
    logic [PCT_W-1:0]       long_pct;
  } cfg_regs_t;

endpackage

`default_nettype wire

// ===== sv/dwsc_fifo.sv =====
`default_nettype none

module dwsc_fifo #(
  parameter int unsigned WIDTH = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic [1:0]       count_nxt;
  logic             wr_en;
  logic             rd_en;

  assign full_o  = (count_r == 2'd2);
  assign empty_o = (count_r == 2'd0);
  assign wr_en   = push_i & ~full_o;
  assign rd_en   = pop_i & ~empty_o;
  assign data_o  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (rd_en) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/dwsc_front.sv =====
`default_nettype none

module dwsc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push_i,
  input  dwsc_pkg::in_word_t            in_word_i,
  input  logic [dwsc_pkg::DATA_W-1:0]   threshold_i,
  output logic                          full_o,
  input  logic                          q_pop_i,
  output logic                          q_valid_o,
  output logic                          q_hot_o
);

  logic hot;
  logic q_empty;

  assign hot = (in_word_i.read_bandwidth > threshold_i) &&
               (in_word_i.page_in_rate > threshold_i);

  dwsc_fifo #(
    .WIDTH(1)
  ) u_hot_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push_i),
    .data_i (hot),
    .full_o (full_o),
    .pop_i  (q_pop_i),
    .data_o (q_hot_o),
    .empty_o(q_empty)
  );

  assign q_valid_o = ~q_empty;

endmodule

`default_nettype wire

// ===== sv/dwsc_window.sv =====
`default_nettype none

module dwsc_window #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned LEN_W = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [LEN_W-1:0]              len_i,
  input  logic [dwsc_pkg::PCT_W-1:0]    pct_i,
  input  logic                          push_i,
  input  logic                          bit_i,
  input  logic                          clear_i,
  output logic [$clog2(DEPTH+1)-1:0]    ones_nxt_o,
  output logic                          above_o,
  output logic                          below_o
);

  import dwsc_pkg::*;

  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PROD_W = CNT_W + PCT_W;

  logic [DEPTH-1:0]  bits_r;
  logic [DEPTH-1:0]  bits_nxt;
  logic [CNT_W-1:0]  fill_r;
  logic [CNT_W-1:0]  fill_nxt;
  logic [CNT_W-1:0]  ones_r;
  logic [CNT_W-1:0]  ones_nxt;
  logic [CNT_W-1:0]  eff_len;
  logic [IDX_W-1:0]  tap;
  logic              full;
  logic              drop;
  logic              full_after;
  logic [PROD_W-1:0] hot_scaled;
  logic [PROD_W-1:0] limit;

  // A length of zero acts as one; a length past the depth acts as the depth.
  always_comb begin
    priority if (len_i == '0) begin
      eff_len = CNT_W'(1);
    end else if (int'(len_i) > int'(DEPTH)) begin
      eff_len = CNT_W'(DEPTH);
    end else begin
      eff_len = CNT_W'(len_i);
    end
  end

  assign tap  = IDX_W'(eff_len - CNT_W'(1));
  assign full = (fill_r >= eff_len);
  assign drop = full & bits_r[tap];

  always_comb begin
    ones_nxt = ones_r - CNT_W'(drop) + CNT_W'(bit_i);
    fill_nxt = full ? eff_len : (fill_r + CNT_W'(1));
    bits_nxt[0] = bit_i;
    for (int i = 1; i < DEPTH; i++) begin
      bits_nxt[i] = (CNT_W'(i) < eff_len) ? bits_r[i-1] : 1'b0;
    end
  end

  assign full_after = (fill_nxt >= eff_len);
  assign hot_scaled = PROD_W'(ones_nxt) * PROD_W'(PCT_SCALE);
  assign limit      = PROD_W'(pct_i) * PROD_W'(eff_len);
  assign above_o    = full_after && (hot_scaled > limit);
  assign below_o    = full_after && (hot_scaled < limit);
  assign ones_nxt_o = ones_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= '0;
      fill_r <= '0;
      ones_r <= '0;
    end else if (clear_i) begin
      bits_r <= '0;
      fill_r <= '0;
      ones_r <= '0;
    end else if (push_i) begin
      bits_r <= bits_nxt;
      fill_r <= fill_nxt;
      ones_r <= ones_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/dwsc_back.sv =====
`default_nettype none

module dwsc_back #(
  parameter int unsigned SHORT_DEPTH = 64,
  parameter int unsigned LONG_DEPTH  = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dwsc_pkg::cfg_regs_t  cfg_i,
  input  logic                 win_clear_i,
  input  logic                 q_valid_i,
  input  logic                 q_hot_i,
  output logic                 q_pop_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output dwsc_pkg::out_word_t  out_word_o
);

  import dwsc_pkg::*;

  localparam int unsigned SHORT_CNT_W = $clog2(SHORT_DEPTH + 1);
  localparam int unsigned LONG_CNT_W  = $clog2(LONG_DEPTH + 1);

  class_t                 state_r;
  class_t                 state_nxt;
  logic                   step;
  logic                   res_full;
  logic                   long_clear;
  logic                   short_above;
  logic                   long_below;
  logic [SHORT_CNT_W-1:0] short_ones;
  logic [LONG_CNT_W-1:0]  long_ones;
  out_word_t              res;

  assign step    = q_valid_i & ~res_full;
  assign q_pop_o = step;

  dwsc_window #(
    .DEPTH(SHORT_DEPTH),
    .LEN_W(SHORT_LEN_W)
  ) u_short_win (
    .clk       (clk),
    .rst_n     (rst_n),
    .len_i     (cfg_i.short_len),
    .pct_i     (cfg_i.short_pct),
    .push_i    (step),
    .bit_i     (q_hot_i),
    .clear_i   (win_clear_i),
    .ones_nxt_o(short_ones),
    .above_o   (short_above),
    .below_o   ()
  );

  dwsc_window #(
    .DEPTH(LONG_DEPTH),
    .LEN_W(LONG_LEN_W)
  ) u_long_win (
    .clk       (clk),
    .rst_n     (rst_n),
    .len_i     (cfg_i.long_len),
    .pct_i     (cfg_i.long_pct),
    .push_i    (step),
    .bit_i     (q_hot_i),
    .clear_i   (win_clear_i | long_clear),
    .ones_nxt_o(long_ones),
    .above_o   (),
    .below_o   (long_below)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CLS_UNKNOWN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    long_clear = 1'b0;
    if (step) begin
      unique case (state_r)
        CLS_NOT_SENS: begin
          if (short_above) begin
            state_nxt  = CLS_SENS;
            long_clear = 1'b1;
          end
        end
        CLS_SENS: begin
          if (long_below) begin
            state_nxt = CLS_NOT_SENS;
          end
        end
        default: begin
          // Unknown and the unused code; the long test wins.
          priority if (long_below) begin
            state_nxt = CLS_NOT_SENS;
          end else if (short_above) begin
            state_nxt = CLS_SENS;
          end else begin
            state_nxt = CLS_UNKNOWN;
          end
        end
      endcase
    end
  end

  always_comb begin
    res.class_code  = state_nxt;
    res.sample_hot  = q_hot_i;
    res.short_count = SHORT_CNT_OUT_W'(short_ones);
    res.long_count  = long_clear ? '0 : LONG_CNT_OUT_W'(long_ones);
  end

  dwsc_fifo #(
    .WIDTH($bits(out_word_t))
  ) u_res_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (step),
    .data_i (res),
    .full_o (res_full),
    .pop_i  (pop_i),
    .data_o (out_word_o),
    .empty_o(empty_o)
  );

endmodule

`default_nettype wire

// ===== sv/dual_window_sensitivity_classifier_core.sv =====
// An accepted word is held in the input queue, then in the result queue, and leaves on the
// result ports; a full result queue stalls it in the input queue.
// Throughput: one word per cycle unless the result queue is full; windows and class update
// together. Reset: synchronous, active-low rst_n empties both queues, clears both windows,
// sets the class to unknown and loads the register defaults. No clearing pass is needed.
`default_nettype none

`include "dual_window_sensitivity_classifier_core_defines.svh"

module dual_window_sensitivity_classifier_core #(
  parameter int unsigned SHORT_DEPTH = 64,
  parameter int unsigned LONG_DEPTH  = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  input  dwsc_pkg::in_word_t               in_word,
  output logic                             full,
  input  logic                             pop,
  output logic                             empty,
  output dwsc_pkg::out_word_t              out_word,
  input  logic                             valid,
  output logic                             ready,
  input  logic [dwsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dwsc_pkg::DATA_W-1:0]      cfg_data
);

  import dwsc_pkg::*;

  cfg_regs_t cfg_r;
  cfg_regs_t cfg_nxt;
  logic      cfg_wr;
  logic      win_clear;
  logic      q_pop;
  logic      q_valid;
  logic      q_hot;

  assign ready  = 1'b1;
  assign cfg_wr = valid & ready;

  always_comb begin
    cfg_nxt   = cfg_r;
    win_clear = 1'b0;
    if (cfg_wr) begin
      unique case (cfg_index)
        CFG_THRESHOLD: cfg_nxt.threshold = cfg_data;
        CFG_SHORT_LEN: begin
          cfg_nxt.short_len = cfg_data[SHORT_LEN_W-1:0];
          win_clear         = 1'b1;
        end
        CFG_LONG_LEN: begin
          cfg_nxt.long_len = cfg_data[LONG_LEN_W-1:0];
          win_clear        = 1'b1;
        end
        CFG_SHORT_PCT: cfg_nxt.short_pct = cfg_data[PCT_W-1:0];
        CFG_LONG_PCT:  cfg_nxt.long_pct  = cfg_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold <= '0;
      cfg_r.short_len <= SHORT_LEN_W'(1);
      cfg_r.long_len  <= LONG_LEN_W'(1);
      cfg_r.short_pct <= '0;
      cfg_r.long_pct  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dwsc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (push),
    .in_word_i  (in_word),
    .threshold_i(cfg_r.threshold),
    .full_o     (full),
    .q_pop_i    (q_pop),
    .q_valid_o  (q_valid),
    .q_hot_o    (q_hot)
  );

  dwsc_back #(
    .SHORT_DEPTH(SHORT_DEPTH),
    .LONG_DEPTH (LONG_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg_r),
    .win_clear_i(win_clear),
    .q_valid_i  (q_valid),
    .q_hot_i    (q_hot),
    .q_pop_o    (q_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_word_o (out_word)
  );

  `DWSC_ASSERT_NEVER(a_full_without_results, clk, rst_n, full && empty)
  `DWSC_ASSERT_IMPL(a_accepted_word_surfaces, clk, rst_n, push && !full |-> ##2 !empty)

endmodule

`default_nettype wire

// ===== verif/dual_window_sensitivity_classifier_core_tb.sv =====
`timescale 1ns / 100ps

module dual_window_sensitivity_classifier_core_tb;
  import dwsc_pkg::*;

  localparam int unsigned SHORT_DEPTH = 64;
  localparam int unsigned LONG_DEPTH  = 256;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_SAMPLES = 1850;
  localparam int unsigned EXP_SLOTS = 16;
  localparam int unsigned STIM_SLOTS = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_LONG_PCT + CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

  typedef enum int {ROW_SAMPLE, ROW_REG} row_kind_t;
  typedef enum int {POP_ALWAYS, POP_COIN, POP_RARE} pop_mode_t;

  typedef struct {
    row_kind_t         kind;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    bit                has_word;
    out_word_t         word;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 push = 1'b0;
  in_word_t             in_word = '0;
  logic                 full;
  logic                 pop = 1'b0;
  logic                 empty;
  out_word_t            out_word;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data = '0;

  dual_window_sensitivity_classifier_core #(
    .SHORT_DEPTH(SHORT_DEPTH),
    .LONG_DEPTH (LONG_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_word  (in_word),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .out_word (out_word),
    .valid    (cfg_valid),
    .ready    (cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Classifier state mirrored by the testbench.
  cfg_regs_t             model_cfg;
  logic [LONG_DEPTH-1:0] short_bits;
  logic [LONG_DEPTH-1:0] long_bits;
  int unsigned           short_fill;
  int unsigned           short_ones;
  int unsigned           long_fill;
  int unsigned           long_ones;
  class_t                class_state;

  out_word_t   exp_ring[EXP_SLOTS];
  int unsigned exp_head = 0;
  int unsigned exp_tail = 0;
  int unsigned exp_count = 0;
  stim_row_t   stim_rows[STIM_SLOTS];
  int unsigned stim_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned samples_sent = 0;
  int unsigned regs_written = 0;
  int unsigned words_checked = 0;
  int unsigned class_seen[4] = '{0, 0, 0, 0};
  int unsigned burst_left = 0;
  int unsigned cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_len(int unsigned len, int unsigned depth);
    if (len == 0) return 1;
    if (len > depth) return depth;
    return len;
  endfunction

  task automatic shift_window(inout logic [LONG_DEPTH-1:0] bits, inout int unsigned fill,
                              inout int unsigned ones, input int unsigned len, input logic b);
    if (fill >= len) begin
      if (bits[len-1]) ones--;
      bits[len-1] = 1'b0;
      fill = len - 1;
    end
    bits = {bits[LONG_DEPTH-2:0], b};
    fill++;
    if (b) ones++;
  endtask

  task automatic reset_model();
    model_cfg = '0;
    model_cfg.short_len = 1;
    model_cfg.long_len = 1;
    short_bits = '0;
    short_fill = 0;
    short_ones = 0;
    long_bits = '0;
    long_fill = 0;
    long_ones = 0;
    class_state = CLS_UNKNOWN;
  endtask

  task automatic apply_register(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    case (idx)
      CFG_THRESHOLD: model_cfg.threshold = data;
      CFG_SHORT_LEN: model_cfg.short_len = data[SHORT_LEN_W-1:0];
      CFG_LONG_LEN:  model_cfg.long_len = data[LONG_LEN_W-1:0];
      CFG_SHORT_PCT: model_cfg.short_pct = data[PCT_W-1:0];
      CFG_LONG_PCT:  model_cfg.long_pct = data[PCT_W-1:0];
      default: ;
    endcase
    // A new window length empties both windows.
    if (idx == CFG_SHORT_LEN || idx == CFG_LONG_LEN) begin
      short_bits = '0;
      short_fill = 0;
      short_ones = 0;
      long_bits = '0;
      long_fill = 0;
      long_ones = 0;
    end
  endtask

  task automatic classify_sample(input in_word_t w, output out_word_t res);
    int unsigned slen;
    int unsigned llen;
    logic        hot;
    bit          short_fire;
    bit          long_fire;
    slen = eff_len(model_cfg.short_len, SHORT_DEPTH);
    llen = eff_len(model_cfg.long_len, LONG_DEPTH);
    hot = (w.read_bandwidth > model_cfg.threshold) && (w.page_in_rate > model_cfg.threshold);
    shift_window(short_bits, short_fill, short_ones, slen, hot);
    shift_window(long_bits, long_fill, long_ones, llen, hot);
    short_fire = (short_fill >= slen) &&
                 (short_ones * PCT_SCALE > int'(model_cfg.short_pct) * slen);
    long_fire = (long_fill >= llen) &&
                (long_ones * PCT_SCALE < int'(model_cfg.long_pct) * llen);
    case (class_state)
      CLS_NOT_SENS: begin
        if (short_fire) begin
          class_state = CLS_SENS;
          long_bits = '0;
          long_fill = 0;
          long_ones = 0;
        end
      end
      CLS_SENS: begin
        if (long_fire) class_state = CLS_NOT_SENS;
      end
      default: begin
        if (long_fire) class_state = CLS_NOT_SENS;
        else if (short_fire) class_state = CLS_SENS;
        else class_state = CLS_UNKNOWN;
      end
    endcase
    res.class_code = class_state;
    res.sample_hot = hot;
    res.short_count = short_ones[SHORT_CNT_OUT_W-1:0];
    res.long_count = long_ones[LONG_CNT_OUT_W-1:0];
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s at word %0d: got %0d, expected %0d", what, words_checked, got, want);
    mismatch_count++;
  endtask

  task automatic store_expected(input out_word_t w);
    if (exp_count == EXP_SLOTS) begin
      report_mismatch("expected words overflow", exp_count, EXP_SLOTS);
    end else begin
      exp_ring[exp_tail] = w;
      exp_tail = (exp_tail + 1) % EXP_SLOTS;
      exp_count++;
    end
  endtask

  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (exp_count == 0) begin
      report_mismatch("unexpected word", got, 0);
    end else begin
      want = exp_ring[exp_head];
      exp_head = (exp_head + 1) % EXP_SLOTS;
      exp_count--;
      if (got.class_code !== want.class_code)
        report_mismatch("class_code", got.class_code, want.class_code);
      if (got.sample_hot !== want.sample_hot)
        report_mismatch("sample_hot", got.sample_hot, want.sample_hot);
      if (got.short_count !== want.short_count)
        report_mismatch("short_count", got.short_count, want.short_count);
      if (got.long_count !== want.long_count)
        report_mismatch("long_count", got.long_count, want.long_count);
    end
    if (!$isunknown(got.class_code)) class_seen[got.class_code]++;
    words_checked++;
  endtask

  task automatic hold_off(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      push = 1'b0;
      in_word = {$urandom, $urandom};
    end
  endtask

  task automatic send_sample(input in_word_t w, input bit has_word, input out_word_t word);
    out_word_t predicted;
    @(negedge clk);
    push = 1'b1;
    in_word = w;
    @(posedge clk);
    while (full) @(posedge clk);
    classify_sample(w, predicted);
    store_expected(has_word ? word : predicted);
    samples_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      if ($urandom_range(0, 9) == 0) hold_off($urandom_range(20, 40));
      else hold_off($urandom_range(1, 10));
      if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(100, 300);
      else burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic wait_for_results();
    hold_off(1);
    while (exp_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_register(idx, data);
    regs_written++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic in_word_t make_sample(int unsigned hot_pct);
    in_word_t          w;
    longint unsigned   thr;
    longint unsigned   headroom;
    logic [DATA_W-1:0] low_val;
    thr = model_cfg.threshold;
    w.read_bandwidth = $urandom;
    w.page_in_rate = $urandom;
    if ($urandom_range(0, 15) == 0) return w;
    if ($urandom_range(0, 99) < hot_pct && thr != 64'hFFFF_FFFF) begin
      headroom = 64'hFFFF_FFFF - thr;
      w.read_bandwidth = thr + 1 + ($urandom % headroom);
      w.page_in_rate = thr + 1 + ($urandom % headroom);
      if ($urandom_range(0, 5) == 0) w.read_bandwidth = thr + 1;
      if ($urandom_range(0, 5) == 0) w.page_in_rate = thr + 1;
    end else begin
      low_val = $urandom % (thr + 1);
      if ($urandom_range(0, 4) == 0) low_val = thr;
      case ($urandom_range(0, 2))
        0: w.read_bandwidth = low_val;
        1: w.page_in_rate = low_val;
        default: begin
          w.read_bandwidth = low_val;
          w.page_in_rate = $urandom % (thr + 1);
        end
      endcase
    end
    return w;
  endfunction

  function automatic void sample_row(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
    stim_rows[stim_count] = '{ROW_SAMPLE, a, b, 1'b0, '0};
    stim_count++;
  endfunction

  function automatic void checked_row(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                      out_word_t word);
    stim_rows[stim_count] = '{ROW_SAMPLE, a, b, 1'b1, word};
    stim_count++;
  endfunction

  function automatic void register_row(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    stim_rows[stim_count] = '{ROW_REG, DATA_W'(idx), data, 1'b0, '0};
    stim_count++;
  endfunction

  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Timed out after %0d cycles with %0d words outstanding", cycle_count,
                 exp_count);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    pop_mode_t   mode;
    int unsigned mode_left;
    mode = POP_ALWAYS;
    mode_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode = pop_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(16, 64);
      end
      mode_left--;
      case (mode)
        POP_ALWAYS: pop = 1'b1;
        POP_COIN:   pop = $urandom_range(0, 1);
        default:    pop = ($urandom_range(0, 7) == 0);
      endcase
      @(posedge clk);
      if (pop && !empty) check_word(out_word);
    end
  end

  initial begin
    int unsigned       directed_count;
    int unsigned       phase_len;
    int unsigned       hot_pct;
    int unsigned       seg_left;
    int unsigned       pick;
    int unsigned       remaining;
    bit                first_phase;
    logic [DATA_W-1:0] value;

    reset_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Defaults: threshold 0, both lengths 1, both percents 0.
    checked_row(32'h0, 32'h0, out_word_t'({CLS_UNKNOWN, 1'b0, 7'd0, 9'd0}));
    checked_row(32'h1, 32'h1, out_word_t'({CLS_SENS, 1'b1, 7'd1, 9'd1}));
    checked_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, out_word_t'({CLS_SENS, 1'b1, 7'd1, 9'd1}));
    checked_row(32'h0, 32'hFFFF_FFFF, out_word_t'({CLS_SENS, 1'b0, 7'd0, 9'd0}));
    register_row(CFG_LONG_PCT, 32'd100);
    checked_row(32'hFFFF_FFFF, 32'h0, out_word_t'({CLS_NOT_SENS, 1'b0, 7'd0, 9'd0}));
    // Going from not sensitive to sensitive empties the long window.
    checked_row(32'h1, 32'h1, out_word_t'({CLS_SENS, 1'b1, 7'd1, 9'd0}));
    register_row(CFG_THRESHOLD, 32'hFFFF_FFFF);
    checked_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, out_word_t'({CLS_NOT_SENS, 1'b0, 7'd0, 9'd0}));
    register_row(CFG_THRESHOLD, 32'h7FFF_FFFF);
    register_row(CFG_SHORT_LEN, 32'hFFFF_FF80);
    register_row(CFG_LONG_LEN, 32'd511);
    register_row(CFG_SHORT_PCT, 32'd127);
    register_row(CFG_LONG_PCT, 32'hFFFF_FF7F);
    sample_row(32'h8000_0000, 32'h8000_0000);
    sample_row(32'h7FFF_FFFF, 32'h8000_0000);
    sample_row(32'h8000_0000, 32'h7FFF_FFFF);
    sample_row(32'h0, 32'h0);
    register_row(CFG_SPARE_LO, 32'hFFFF_FFFF);
    register_row(CFG_SPARE_HI, 32'h0000_0002);
    register_row(CFG_SHORT_LEN, 32'd127);
    register_row(CFG_LONG_LEN, 32'h0);
    register_row(CFG_SHORT_PCT, 32'd100);
    register_row(CFG_LONG_PCT, 32'h0);
    sample_row(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    sample_row(32'h5555_5555, 32'hAAAA_AAAA);
    sample_row(32'h1234_5678, 32'h0);
    register_row(CFG_SHORT_LEN, 32'd2);
    register_row(CFG_LONG_LEN, 32'd2);
    register_row(CFG_SHORT_PCT, 32'd49);
    register_row(CFG_LONG_PCT, 32'd51);
    sample_row(32'hFFFF_FFFF, 32'h8000_0001);
    sample_row(32'h0, 32'hFFFF_FFFF);
    sample_row(32'h8000_0000, 32'h8000_0000);
    sample_row(32'hC000_0000, 32'hF000_0000);
    sample_row(32'h1, 32'h7FFF_FFFF);
    sample_row(32'h7FFF_FFFF, 32'h7FFF_FFFF);

    for (int unsigned i = 0; i < stim_count; i++) begin
      if (stim_rows[i].kind == ROW_REG) begin
        wait_for_results();
        write_register(stim_rows[i].a[CFG_IDX_W-1:0], stim_rows[i].b);
      end else begin
        send_sample(in_word_t'({stim_rows[i].a, stim_rows[i].b}), stim_rows[i].has_word,
                    stim_rows[i].word);
      end
    end
    directed_count = samples_sent;

    first_phase = 1'b1;
    seg_left = 0;
    hot_pct = 50;
    while (samples_sent - directed_count < RANDOM_SAMPLES) begin
      wait_for_results();
      if (first_phase || $urandom_range(0, 9) < 6) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) value = '0;
        else if (pick == 1) value = '1;
        else value = $urandom;
        write_register(CFG_THRESHOLD, value);
      end
      if (first_phase || $urandom_range(0, 9) < 6) begin
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 2))
            0: value = 0;
            1: value = SHORT_DEPTH;
            default: value = $urandom_range(SHORT_DEPTH + 1, 127);
          endcase
        end else begin
          value = $urandom_range(1, 8);
        end
        write_register(CFG_SHORT_LEN, ($urandom & ~32'h7F) | value);
      end
      if (first_phase || $urandom_range(0, 9) < 6) begin
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 2))
            0: value = 0;
            1: value = LONG_DEPTH;
            default: value = $urandom_range(LONG_DEPTH + 1, 511);
          endcase
        end else begin
          value = $urandom_range(1, 20);
        end
        write_register(CFG_LONG_LEN, ($urandom & ~32'h1FF) | value);
      end
      if (first_phase || $urandom_range(0, 9) < 6) begin
        value = ($urandom_range(0, 7) == 0) ? $urandom_range(101, 127) : $urandom_range(0, 100);
        write_register(CFG_SHORT_PCT, ($urandom & ~32'h7F) | value);
      end
      if (first_phase || $urandom_range(0, 9) < 6) begin
        value = ($urandom_range(0, 7) == 0) ? $urandom_range(101, 127) : $urandom_range(0, 100);
        write_register(CFG_LONG_PCT, ($urandom & ~32'h7F) | value);
      end
      if ($urandom_range(0, 5) == 0)
        write_register($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI), $urandom);
      first_phase = 1'b0;

      if (eff_len(model_cfg.long_len, LONG_DEPTH) > 24)
        phase_len = $urandom_range(eff_len(model_cfg.long_len, LONG_DEPTH) + 40,
                                   eff_len(model_cfg.long_len, LONG_DEPTH) + 200);
      else
        phase_len = $urandom_range(20, 90);
      remaining = RANDOM_SAMPLES - (samples_sent - directed_count);
      if (phase_len > remaining) phase_len = remaining;
      repeat (phase_len) begin
        if (seg_left == 0) begin
          case ($urandom_range(0, 5))
            0: hot_pct = 0;
            1: hot_pct = 100;
            2: hot_pct = 10;
            3: hot_pct = 90;
            default: hot_pct = $urandom_range(0, 100);
          endcase
          seg_left = $urandom_range(5, 40);
        end
        seg_left--;
        send_sample(make_sample(hot_pct), 1'b0, '0);
      end
    end

    hold_off(1);
    while (exp_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d samples (%0d directed) and %0d register writes; %0d words checked.",
             samples_sent, directed_count, regs_written, words_checked);
    $display("Classes seen: unknown %0d, not sensitive %0d, sensitive %0d.",
             class_seen[CLS_UNKNOWN], class_seen[CLS_NOT_SENS], class_seen[CLS_SENS]);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
